// File: rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants of the pressure / temperature compensation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptc_pkg;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_SENS_COEFF      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFF_COEFF       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SENS_TEMP_COEFF = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OFF_TEMP_COEFF  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TREF_COEFF      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TSENS_COEFF     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_RANGE      = 3'd6;

  // input item
  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } ptc_in_t;

  // result item
  typedef struct packed {
    logic signed [19:0] pressure_tenth_mbar;
    logic signed [15:0] temperature_centi_c;
  } ptc_out_t;

  // calibration set
  typedef struct packed {
    logic [15:0] sens_coeff;
    logic [15:0] off_coeff;
    logic [15:0] sens_temp_coeff;
    logic [15:0] off_temp_coeff;
    logic [15:0] tref_coeff;
    logic [15:0] tsens_coeff;
    logic        high_range_model;
  } ptc_cfg_t;

  // after the input stage: raw pressure and temperature difference
  typedef struct packed {
    logic        [23:0] d1;
    logic signed [24:0] dt;
  } ptc_s1_t;

  // after first-order compensation
  typedef struct packed {
    logic        [23:0] d1;
    logic signed [18:0] dtemp;   // TEMP - 2000
    logic signed [35:0] off1;
    logic signed [35:0] sens1;
    logic        [17:0] t2;
  } ptc_s3_t;

  // after second-order compensation
  typedef struct packed {
    logic        [23:0] d1;
    logic signed [41:0] off;
    logic signed [40:0] sens;
    logic signed [15:0] temp;
  } ptc_s6_t;

endpackage

// File: rtl/ptc_first.sv
// ----------------------------------------------------------------------------
// ptc_first
// First-order compensation: products of dT, then TEMP, OFF, SENS and T2.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptc_first import ptc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  ptc_cfg_t cfg,
  input  logic     in_valid,
  input  ptc_s1_t  in_item,
  output logic     out_valid,
  output ptc_s3_t  out_item
);

  // product stage registers
  logic               mul_valid;
  logic        [23:0] mul_d1;
  logic signed [41:0] dtts;
  logic        [48:0] dtsq;
  logic signed [41:0] otdt;
  logic signed [41:0] stdt;

  logic signed [41:0] dtts_next;
  logic signed [49:0] dtsq_full;
  logic signed [41:0] otdt_next;
  logic signed [41:0] stdt_next;

  logic signed [41:0] dtts_adj;
  logic signed [41:0] otdt_adj;
  logic signed [41:0] stdt_adj;
  logic        [50:0] dtsq3;
  logic        [51:0] dtsq7;
  logic        [17:0] t2_low;
  logic        [17:0] t2_high;
  logic signed [18:0] dtemp_next;

  // the four products of dT
  assign dtts_next = $signed(in_item.dt) * $signed({1'b0, cfg.tsens_coeff});
  assign dtsq_full = $signed(in_item.dt) * $signed(in_item.dt);
  assign otdt_next = $signed({1'b0, cfg.off_temp_coeff}) * $signed(in_item.dt);
  assign stdt_next = $signed({1'b0, cfg.sens_temp_coeff}) * $signed(in_item.dt);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else begin
      mul_valid <= in_valid;
    end
    mul_d1 <= in_item.d1;
    dtts   <= dtts_next;
    dtsq   <= dtsq_full[48:0];
    otdt   <= otdt_next;
    stdt   <= stdt_next;
  end

  // divisions truncate toward zero: bias negatives before the shift
  assign dtts_adj = dtts + (dtts[41] ? 42'sd8388607 : 42'sd0);
  assign otdt_adj = otdt + (otdt[41] ? 42'sd127 : 42'sd0);
  assign stdt_adj = stdt + (stdt[41] ? 42'sd255 : 42'sd0);
  assign dtemp_next = dtts_adj[41:23];

  // second-order temperature terms, both branches
  assign dtsq3   = {1'b0, dtsq, 1'b0} + {2'b00, dtsq};
  assign dtsq7   = {dtsq, 3'b000} - {3'b000, dtsq};
  assign t2_low  = dtsq3[50:33];
  assign t2_high = {3'b000, dtsq7[51:37]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= mul_valid;
    end
    out_item.d1    <= mul_d1;
    out_item.dtemp <= dtemp_next;
    out_item.off1  <= $signed({4'h0, cfg.off_coeff, 16'h0000})
                      + $signed({otdt_adj[41], otdt_adj[41:7]});
    out_item.sens1 <= $signed({5'h00, cfg.sens_coeff, 15'h0000})
                      + $signed({{2{stdt_adj[41]}}, stdt_adj[41:8]});
    out_item.t2    <= dtemp_next[18] ? t2_low : t2_high;
  end

endmodule

// File: rtl/ptc_second.sv
// ----------------------------------------------------------------------------
// ptc_second
// Second-order compensation: OFF2 and SENS2 terms, corrected OFF, SENS, TEMP.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptc_second import ptc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  ptc_s3_t in_item,
  output logic    out_valid,
  output ptc_s6_t out_item
);

  // square stage
  logic               sq_valid;
  logic        [23:0] sq_d1;
  logic signed [35:0] sq_off1;
  logic signed [35:0] sq_sens1;
  logic        [34:0] dev;
  logic        [35:0] dev_low;
  logic               below_20;
  logic               below_m15;
  logic signed [19:0] temp_full;

  // correction term stage
  logic               cor_valid;
  logic        [23:0] cor_d1;
  logic signed [35:0] cor_off1;
  logic signed [35:0] cor_sens1;
  logic        [39:0] off2;
  logic        [38:0] sens2;
  logic signed [15:0] cor_temp;

  logic signed [37:0] dev_full;
  logic signed [19:0] dtemp_low;
  logic signed [39:0] dev_low_full;
  logic signed [19:0] temp_full_next;
  logic        [39:0] dev3;
  logic        [36:0] dev5;
  logic        [38:0] dev_low7;
  logic        [39:0] off2_base;
  logic        [38:0] sens2_base;
  logic        [39:0] off2_next;
  logic        [38:0] sens2_next;
  logic signed [15:0] temp_sat;

  // squares of the temperature offsets from 20 C and -15 C
  assign dev_full       = in_item.dtemp * in_item.dtemp;
  assign dtemp_low      = $signed({in_item.dtemp[18], in_item.dtemp}) + 20'sd3500;
  assign dev_low_full   = dtemp_low * dtemp_low;
  assign temp_full_next = 20'sd2000 + $signed({in_item.dtemp[18], in_item.dtemp})
                          - $signed({2'b00, in_item.t2});

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else begin
      sq_valid <= in_valid;
    end
    sq_d1     <= in_item.d1;
    sq_off1   <= in_item.off1;
    sq_sens1  <= in_item.sens1;
    dev       <= dev_full[34:0];
    dev_low   <= dev_low_full[35:0];
    below_20  <= in_item.dtemp[18];
    below_m15 <= in_item.dtemp < -19'sd3500;
    temp_full <= temp_full_next;
  end

  // OFF2 and SENS2 by range
  assign dev3       = {4'h0, dev, 1'b0} + {5'h00, dev};
  assign dev5       = {dev, 2'b00} + {2'b00, dev};
  assign dev_low7   = {dev_low, 3'b000} - {3'b000, dev_low};
  assign off2_base  = below_20 ? {1'b0, dev3[39:1]} : {9'h000, dev[34:4]};
  assign sens2_base = below_20 ? {5'h00, dev5[36:3]} : 39'd0;
  assign off2_next  = off2_base + (below_m15 ? {1'b0, dev_low7} : 40'd0);
  assign sens2_next = sens2_base + (below_m15 ? {1'b0, dev_low, 2'b00} : 39'd0);

  // temperature saturation
  always_comb begin
    if (temp_full > 20'sd32767) begin
      temp_sat = 16'sh7fff;
    end else if (temp_full < -20'sd32768) begin
      temp_sat = -16'sh8000;
    end else begin
      temp_sat = temp_full[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cor_valid <= 1'b0;
    end else begin
      cor_valid <= sq_valid;
    end
    cor_d1    <= sq_d1;
    cor_off1  <= sq_off1;
    cor_sens1 <= sq_sens1;
    off2      <= off2_next;
    sens2     <= sens2_next;
    cor_temp  <= temp_sat;
  end

  // apply the corrections
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cor_valid;
    end
    out_item.d1   <= cor_d1;
    out_item.off  <= $signed({{6{cor_off1[35]}}, cor_off1}) - $signed({2'b00, off2});
    out_item.sens <= $signed({{5{cor_sens1[35]}}, cor_sens1}) - $signed({2'b00, sens2});
    out_item.temp <= cor_temp;
  end

endmodule

// File: rtl/ptc_press.sv
// ----------------------------------------------------------------------------
// ptc_press
// Pressure: D1 * SENS in two partial products, scaling, OFF removal, range divide, clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptc_press import ptc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     high_range_model,
  input  logic     in_valid,
  input  ptc_s6_t  in_item,
  output logic     out_valid,
  output ptc_out_t out_item
);

  // partial product stage
  logic               pp_valid;
  logic        [44:0] p_lo;
  logic signed [44:0] p_hi;
  logic signed [41:0] pp_off;
  logic signed [15:0] pp_temp;

  // full product stage
  logic               pr_valid;
  logic signed [65:0] prod;
  logic signed [41:0] pr_off;
  logic signed [15:0] pr_temp;

  // offset removed stage
  logic               ac_valid;
  logic signed [45:0] acc;
  logic signed [15:0] ac_temp;

  logic        [44:0] p_lo_next;
  logic signed [44:0] p_hi_next;
  logic signed [65:0] prod_adj;
  logic signed [44:0] prod_scaled;
  logic signed [45:0] acc_adj13;
  logic signed [45:0] acc_adj15;
  logic signed [32:0] pres_div;
  logic signed [19:0] pres_sat;

  // split SENS at bit 21 so each multiplier stays narrow
  assign p_lo_next = in_item.d1 * in_item.sens[20:0];
  assign p_hi_next = $signed({1'b0, in_item.d1}) * $signed(in_item.sens[40:21]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_valid <= 1'b0;
    end else begin
      pp_valid <= in_valid;
    end
    p_lo    <= p_lo_next;
    p_hi    <= p_hi_next;
    pp_off  <= in_item.off;
    pp_temp <= in_item.temp;
  end

  // recombine partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      pr_valid <= 1'b0;
    end else begin
      pr_valid <= pp_valid;
    end
    prod    <= $signed({p_hi, 21'h000000}) + $signed({21'h000000, p_lo});
    pr_off  <= pp_off;
    pr_temp <= pp_temp;
  end

  // truncating divide by 2^21, then subtract OFF
  assign prod_adj    = prod + (prod[65] ? 66'sd2097151 : 66'sd0);
  assign prod_scaled = prod_adj[65:21];

  always_ff @(posedge clk) begin
    if (rst) begin
      ac_valid <= 1'b0;
    end else begin
      ac_valid <= pr_valid;
    end
    acc     <= $signed({prod_scaled[44], prod_scaled})
               - $signed({{4{pr_off[41]}}, pr_off});
    ac_temp <= pr_temp;
  end

  // truncating divide by the range divisor, then clamp
  assign acc_adj13 = acc + (acc[45] ? 46'sd8191 : 46'sd0);
  assign acc_adj15 = acc + (acc[45] ? 46'sd32767 : 46'sd0);
  assign pres_div  = high_range_model ? acc_adj13[45:13]
                                      : $signed({{2{acc_adj15[45]}}, acc_adj15[45:15]});

  always_comb begin
    if (pres_div > 33'sd524287) begin
      pres_sat = 20'sh7ffff;
    end else if (pres_div < -33'sd524288) begin
      pres_sat = -20'sh80000;
    end else begin
      pres_sat = pres_div[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ac_valid;
    end
    out_item.pressure_tenth_mbar <= pres_sat;
    out_item.temperature_centi_c <= ac_temp;
  end

endmodule

// File: rtl/pressure_temp_compensation_top.sv
// ----------------------------------------------------------------------------
// pressure_temp_compensation_top
// Second-order pressure and temperature compensation of raw conversion pairs.
// ----------------------------------------------------------------------------
// Results: result_valid marks each result, in the order in which start was taken.
// Throughput: one item per cycle; ten register stages, the two-part D1 * SENS
// product and the range divide setting the depth of the pressure path.
// Reset: synchronous; clears all stage valid bits, calibration words to 0 and
// the range flag to 1. busy is high only during reset; results cannot be stalled.
`timescale 1ns / 1ps

module pressure_temp_compensation_top import ptc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  ptc_in_t                sample,
  output logic                   result_valid,
  output ptc_out_t               result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data
);

  ptc_cfg_t cfg;
  logic     s1_valid;
  ptc_s1_t  s1_item;
  logic     s3_valid;
  ptc_s3_t  s3_item;
  logic     s6_valid;
  ptc_s6_t  s6_item;

  assign busy      = rst;
  assign cfg_ready = !rst;

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sens_coeff       <= 16'h0000;
      cfg.off_coeff        <= 16'h0000;
      cfg.sens_temp_coeff  <= 16'h0000;
      cfg.off_temp_coeff   <= 16'h0000;
      cfg.tref_coeff       <= 16'h0000;
      cfg.tsens_coeff      <= 16'h0000;
      cfg.high_range_model <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SENS_COEFF:      cfg.sens_coeff       <= cfg_data;
        REG_OFF_COEFF:       cfg.off_coeff        <= cfg_data;
        REG_SENS_TEMP_COEFF: cfg.sens_temp_coeff  <= cfg_data;
        REG_OFF_TEMP_COEFF:  cfg.off_temp_coeff   <= cfg_data;
        REG_TREF_COEFF:      cfg.tref_coeff       <= cfg_data;
        REG_TSENS_COEFF:     cfg.tsens_coeff      <= cfg_data;
        REG_HIGH_RANGE:      cfg.high_range_model <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // input stage: capture D1 and form dT = D2 - tref * 256
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_item.d1 <= sample.raw_pressure;
    s1_item.dt <= $signed({1'b0, sample.raw_temperature})
                  - $signed({1'b0, cfg.tref_coeff, 8'h00});
  end

  ptc_first u_first (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s1_valid),
    .in_item   (s1_item),
    .out_valid (s3_valid),
    .out_item  (s3_item)
  );

  ptc_second u_second (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .in_item   (s3_item),
    .out_valid (s6_valid),
    .out_item  (s6_item)
  );

  ptc_press u_press (
    .clk              (clk),
    .rst              (rst),
    .high_range_model (cfg.high_range_model),
    .in_valid         (s6_valid),
    .in_item          (s6_item),
    .out_valid        (result_valid),
    .out_item         (result)
  );

endmodule

// File: rtl/ptc_checker.sv
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks of the compensation block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid
);

  logic item_taken;
  assign item_taken = start && !busy;

  // the block never holds off an item outside reset
  a_never_busy: assert property (@(posedge clk) !rst |-> !busy)
    else $error("busy high outside reset");

  // every item taken is followed by a result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    item_taken |-> ##10 result_valid)
    else $error("item taken without a result ten cycles later");

  // no result without a matching item taken before it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(item_taken, 10))
    else $error("result with no matching item");

  // reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result strobe right after reset");

endmodule

bind pressure_temp_compensation_top ptc_checker u_ptc_checker (.*);

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the pressure / temperature compensation block. A stimulus table
// runs the field extremes, the branch points of the second-order correction
// and saturation over a few calibration sets. Then come phases of random
// samples, each under a freshly written calibration. Every result is checked
// against a typed row's value or the behavioral compensation model kept here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import ptc_pkg::*; ();

  localparam int LATENCY = 10;
  localparam int N_DIR = 20;
  localparam int N_PHASES = 10;
  localparam int PHASE_ITEMS = 105;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  localparam longint DIV_2P21 = 64'sd2097152;
  localparam longint DIV_2P23 = 64'sd8388608;
  localparam longint DIV_2P33 = 64'sd8589934592;
  localparam longint DIV_2P37 = 64'sd137438953472;

  // one row of the directed stimulus table
  typedef struct {
    int          cal_set;
    logic [23:0] p;
    logic [23:0] t;
    bit          typed;
    int          exp_p;
    int          exp_t;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  ptc_in_t                sample;
  logic                   result_valid;
  ptc_out_t               result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [15:0]            cfg_data;

  ptc_cfg_t cal;
  ptc_out_t expected_readings [$];
  ptc_out_t want;
  int       mismatches;
  int       idle_pct;
  int       cur_set;

  // calibration sets of the directed part; entry 0 is the reset state
  ptc_cfg_t cal_sets [4] = '{
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0},
    '{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165, 1'b1},
    '{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'hFFFF, 16'hFFFF, 1'b0}
  };

  // directed samples; typed rows hold the result under reset calibration
  stim_row_t dir_tab [N_DIR] = '{
    '{0, 24'h000000, 24'h000000, 1'b1, 0, 2000},
    '{0, 24'hFFFFFF, 24'h000000, 1'b1, 0, 2000},
    '{0, 24'h000000, 24'hFFFFFF, 1'b1, 0, -12335},
    '{0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 0, -12335},
    '{0, 24'hAAAAAA, 24'h555555, 1'b0, 0, 0},
    '{1, 24'h000000, 24'h000000, 1'b0, 0, 0},
    '{1, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 0, 0},
    '{1, 24'hFFFFFF, 24'h000000, 1'b0, 0, 0},
    '{1, 24'h000000, 24'hFFFFFF, 1'b0, 0, 0},
    '{1, 24'h800000, 24'hFFFF00, 1'b0, 0, 0},
    '{2, 24'd4311550, 24'd8077568, 1'b0, 0, 0},
    '{2, 24'd4311550, 24'd8077567, 1'b0, 0, 0},
    '{2, 24'd4311550, 24'd8569685, 1'b0, 0, 0},
    '{2, 24'd4311550, 24'd6291456, 1'b0, 0, 0},
    '{2, 24'd4311550, 24'd7035135, 1'b0, 0, 0},
    '{2, 24'd4311550, 24'd7034837, 1'b0, 0, 0},
    '{2, 24'd4311550, 24'd1048576, 1'b0, 0, 0},
    '{3, 24'h000000, 24'h000000, 1'b0, 0, 0},
    '{3, 24'hFFFFFF, 24'h000000, 1'b0, 0, 0},
    '{3, 24'h555555, 24'hFFFFFF, 1'b0, 0, 0}
  };

  pressure_temp_compensation_top DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample       (sample),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // compensated pressure and temperature of one sample under the current calibration
  function automatic ptc_out_t compensate(input ptc_in_t s);
    longint d1, d2, dt, tc, t2, off2, sens2, off, sens, dev, lo, pres, divisor;
    longint c_sens, c_off, c_sens_t, c_off_t, c_tref, c_tsens;
    ptc_out_t r;
    d1 = s.raw_pressure;
    d2 = s.raw_temperature;
    c_sens = cal.sens_coeff;
    c_off = cal.off_coeff;
    c_sens_t = cal.sens_temp_coeff;
    c_off_t = cal.off_temp_coeff;
    c_tref = cal.tref_coeff;
    c_tsens = cal.tsens_coeff;

    // first-order temperature
    dt = d2 - c_tref * 256;
    tc = 2000 + (dt * c_tsens) / DIV_2P23;

    // second-order corrections, cold and warm
    dev = (tc - 2000) * (tc - 2000);
    if (tc < 2000) begin
      t2 = (3 * (dt * dt)) / DIV_2P33;
      off2 = (3 * dev) / 2;
      sens2 = (5 * dev) / 8;
    end else begin
      t2 = (7 * (dt * dt)) / DIV_2P37;
      off2 = dev / 16;
      sens2 = 0;
    end
    // extra term for very cold
    if (tc < -1500) begin
      lo = (tc + 1500) * (tc + 1500);
      off2 = off2 + 7 * lo;
      sens2 = sens2 + 4 * lo;
    end

    off = c_off * 65536 + (c_off_t * dt) / 128 - off2;
    sens = c_sens * 32768 + (c_sens_t * dt) / 256 - sens2;
    tc = tc - t2;

    divisor = cal.high_range_model ? 64'sd8192 : 64'sd32768;
    pres = ((d1 * sens) / DIV_2P21 - off) / divisor;

    // saturate to the output widths
    if (pres < -524288) pres = -524288;
    if (pres > 524287) pres = 524287;
    if (tc < -32768) tc = -32768;
    if (tc > 32767) tc = 32767;
    r.pressure_tenth_mbar = pres[19:0];
    r.temperature_centi_c = tc[15:0];
    return r;
  endfunction

  // calibration register write as the block sees it
  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [15:0] d);
    case (idx)
      REG_SENS_COEFF:      cal.sens_coeff = d;
      REG_OFF_COEFF:       cal.off_coeff = d;
      REG_SENS_TEMP_COEFF: cal.sens_temp_coeff = d;
      REG_OFF_TEMP_COEFF:  cal.off_temp_coeff = d;
      REG_TREF_COEFF:      cal.tref_coeff = d;
      REG_TSENS_COEFF:     cal.tsens_coeff = d;
      REG_HIGH_RANGE:      cal.high_range_model = d[0];
      default: ;
    endcase
  endfunction

  // one calibration word: zero, full scale, near a typical sensor, or anything
  function automatic logic [15:0] rand_word(input int typical);
    int pick;
    int v;
    pick = $urandom_range(9);
    v = typical + int'($urandom_range(4095)) - 2048;
    if (pick == 0) return 16'd0;
    if (pick == 1) return 16'hFFFF;
    if (pick < 5) return v[15:0];
    return 16'($urandom);
  endfunction

  // random calibration set
  function automatic ptc_cfg_t rand_cal();
    ptc_cfg_t c;
    c.sens_coeff = rand_word(46372);
    c.off_coeff = rand_word(43981);
    c.sens_temp_coeff = rand_word(29059);
    c.off_temp_coeff = rand_word(27842);
    c.tref_coeff = rand_word(31553);
    c.tsens_coeff = rand_word(28165);
    c.high_range_model = 1'($urandom_range(1));
    return c;
  endfunction

  // random raw pair, partly steered to the extremes or the reference temperature
  function automatic ptc_in_t rand_sample();
    ptc_in_t s;
    int mode;
    longint mid_code;
    s.raw_pressure = 24'($urandom);
    s.raw_temperature = 24'($urandom);
    mode = $urandom_range(9);
    mid_code = cal.tref_coeff;
    mid_code = mid_code * 256;
    if (mode == 6) s.raw_pressure = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
    if (mode == 7) s.raw_temperature = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
    if (mode >= 8) begin
      if (mode == 8) mid_code = mid_code + int'($urandom_range(8191)) - 4096;
      else mid_code = mid_code + int'($urandom_range(2097151)) - 1048576;
      if (mid_code < 0) mid_code = 0;
      if (mid_code > 16777215) mid_code = 16777215;
      s.raw_temperature = mid_code[23:0];
    end
    return s;
  endfunction

  // present one item, called and returning at a falling edge
  task automatic send_item(input ptc_in_t s, input bit typed,
                           input int exp_p, input int exp_t);
    ptc_out_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    sample <= s;
    do @(posedge clk); while (busy);
    if (typed) begin
      r.pressure_tenth_mbar = exp_p[19:0];
      r.temperature_centi_c = exp_t[15:0];
    end else begin
      r = compensate(s);
    end
    expected_readings.push_back(r);
    @(negedge clk);
  endtask

  // hold the sender until every expected reading is back
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (expected_readings.size() != 0) @(negedge clk);
  endtask

  // one register write over the configuration channel
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] d);
    while ($urandom_range(99) < idle_pct) begin
      cfg_valid <= 1'b0;
      @(negedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, d);
    @(negedge clk);
  endtask

  // write a full calibration set in random order, maybe with a write to no register
  task automatic load_cal(input ptc_cfg_t c);
    logic [CFG_INDEX_W-1:0] order [7];
    logic [CFG_INDEX_W-1:0] tmp;
    logic [15:0]            d;
    logic [31:0]            rnd;
    int                     j;
    order = '{REG_SENS_COEFF, REG_OFF_COEFF, REG_SENS_TEMP_COEFF, REG_OFF_TEMP_COEFF,
              REG_TREF_COEFF, REG_TSENS_COEFF, REG_HIGH_RANGE};
    for (int i = 6; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < 7; i++) begin
      rnd = $urandom;
      case (order[i])
        REG_SENS_COEFF:      d = c.sens_coeff;
        REG_OFF_COEFF:       d = c.off_coeff;
        REG_SENS_TEMP_COEFF: d = c.sens_temp_coeff;
        REG_OFF_TEMP_COEFF:  d = c.off_temp_coeff;
        REG_TREF_COEFF:      d = c.tref_coeff;
        REG_TSENS_COEFF:     d = c.tsens_coeff;
        default:             d = {rnd[14:0], c.high_range_model};
      endcase
      write_reg(order[i], d);
    end
    if ($urandom_range(1)) write_reg(REG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // result checking
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_readings.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, pressure %0d temperature %0d", $time,
                 $signed(result.pressure_tenth_mbar), $signed(result.temperature_centi_c));
      end else begin
        want = expected_readings.pop_front();
        if (result.pressure_tenth_mbar !== want.pressure_tenth_mbar) begin
          mismatches++;
          $display("%0t: pressure mismatch, expected %0d, actual %0d", $time,
                   $signed(want.pressure_tenth_mbar), $signed(result.pressure_tenth_mbar));
        end
        if (result.temperature_centi_c !== want.temperature_centi_c) begin
          mismatches++;
          $display("%0t: temperature mismatch, expected %0d, actual %0d", $time,
                   $signed(want.temperature_centi_c), $signed(result.temperature_centi_c));
        end
      end
    end
  end

  // stimulus
  initial begin
    ptc_in_t s;
    ptc_cfg_t c;
    rst = 1'b1;
    start = 1'b0;
    sample = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    idle_pct = 36;
    cal = cal_sets[0];
    cur_set = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_tab[i].cal_set != cur_set) begin
        wait_drained();
        cur_set = dir_tab[i].cal_set;
        load_cal(cal_sets[cur_set]);
      end
      s.raw_pressure = dir_tab[i].p;
      s.raw_temperature = dir_tab[i].t;
      send_item(s, dir_tab[i].typed, dir_tab[i].exp_p, dir_tab[i].exp_t);
    end

    // random phases, each under its own calibration
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      c = rand_cal();
      if (ph == 0) c = '0;
      if (ph == 1) c = '1;
      idle_pct = (ph == 4) ? 0 : 36;
      load_cal(c);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 6 && i == PHASE_ITEMS / 2) wait_drained();
        send_item(rand_sample(), 1'b0, 0, 0);
      end
    end

    // drain and report
    wait_drained();
    repeat (LATENCY + 2) @(posedge clk);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// File: files.f
rtl/ptc_pkg.sv
rtl/ptc_first.sv
rtl/ptc_second.sv
rtl/ptc_press.sv
rtl/pressure_temp_compensation_top.sv
rtl/ptc_checker.sv
test/tb_top.sv
